// ===== rtl/core/ftq_pkg.sv =====
// Shared types and constants of the frequency table quantizer.
`default_nettype none
package ftq_pkg;

    localparam int ALPHABET    = 256;
    localparam int CDF_TOTAL   = 65536;
    localparam int WEIGHT_BITS = 16;

    localparam int IDX_W  = $clog2(ALPHABET);
    localparam int CNT_W  = $clog2(ALPHABET + 1);
    localparam int CUM_W  = 17;
    localparam int SUM_W  = WEIGHT_BITS + IDX_W;
    localparam int SPREAD = CDF_TOTAL - ALPHABET;
    localparam int SPR_W  = $clog2(SPREAD + 1);
    localparam int PROD_W = WEIGHT_BITS + SPR_W;
    localparam int UNI_STEP = CDF_TOTAL / ALPHABET;

    localparam logic [1:0] REQ_WRITE = 2'd0;
    localparam logic [1:0] REQ_BUILD = 2'd1;
    localparam logic [1:0] REQ_READ  = 2'd2;

    typedef enum logic [4:0] {
        S_IDLE, S_RD_WAIT, S_RD_OUT, S_SUM, S_CHECK, S_DV_RD, S_DV_MUL, S_DV_START,
        S_DV_RUN, S_DV_WR, S_MISS, S_RK_RD, S_RK_LD, S_RK_SCAN, S_RK_DEC, S_PRE_CLR,
        S_PRE, S_FIN_OK, S_FIN_ERR
    } t_state;

    typedef enum logic [4:0] {
        DOP_NONE, DOP_IDLE, DOP_SUM, DOP_KCLR, DOP_DRD, DOP_DMUL, DOP_DSTART, DOP_DWR,
        DOP_MISS, DOP_RRD, DOP_RLD, DOP_RSCAN, DOP_RDEC, DOP_PCLR, DOP_PRE, DOP_FIN_OK,
        DOP_FIN_ERR, DOP_RD_OUT
    } t_dop;

    typedef struct packed {
        logic take;
        t_dop op;
    } t_cmd;

    typedef struct packed {
        logic k_last;
        logic k_end;
        logic j_end;
        logic div_busy;
        logic sum_zero;
        logic miss_zero;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

// ===== rtl/core/ftq_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module ftq_ram #(
    parameter int W     = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);
    logic [W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ===== rtl/core/ftq_div.sv =====
// Restoring divider that retires one quotient bit per cycle.
`default_nettype none
module ftq_div #(
    parameter int N_W = 32,
    parameter int D_W = 24
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_busy,
    output logic      [N_W-1:0] o_quot,
    output logic      [D_W-1:0] o_rem
);
    localparam int C_W = $clog2(N_W + 1);

    logic [C_W-1:0] r_cnt;
    logic [N_W-1:0] r_q;
    logic [D_W-1:0] r_rem;
    logic [D_W-1:0] r_d;
    logic [D_W:0]   trial;
    logic           ge;

    assign trial = {r_rem, r_q[N_W-1]};
    assign ge    = trial >= {1'b0, r_d};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_start) begin
            r_cnt <= C_W'(N_W);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - C_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_d   <= i_divisor;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_rem <= ge ? D_W'(trial - {1'b0, r_d}) : trial[D_W-1:0];
            r_q   <= {r_q[N_W-2:0], ge};
        end
    end

    assign o_busy = r_cnt != '0;
    assign o_quot = r_q;
    assign o_rem  = r_rem;
endmodule
`default_nettype wire

// ===== rtl/core/ftq_dp.sv =====
// Datapath: weight and table memories, sum, divide, ranking and prefix sum.
`default_nettype none
module ftq_dp (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire ftq_pkg::t_cmd   i_cmd,
    input  wire logic [1:0]      i_req_type,
    input  wire logic [8:0]      i_entry_index,
    input  wire logic [15:0]     i_weight,
    input  wire logic            i_out_stall,
    output ftq_pkg::t_stat       o_stat,
    output logic                 o_valid,
    output logic [16:0]          o_cum_value,
    output logic                 o_status
);
    localparam int IW = ftq_pkg::IDX_W;
    localparam int CW = ftq_pkg::CNT_W;
    localparam int UW = ftq_pkg::CUM_W;
    localparam int SW = ftq_pkg::SUM_W;
    localparam int PW = ftq_pkg::PROD_W;
    localparam int WB = ftq_pkg::WEIGHT_BITS;
    localparam int NA = ftq_pkg::ALPHABET;

    logic [CW-1:0] r_k, r_j, r_ridx, r_rank;
    logic [IW-1:0] r_kd, r_jd;
    logic          r_pend, r_wvd, r_built, r_ov, r_out_st;
    logic [NA-1:0] r_wv;
    logic [SW-1:0] r_sum, r_ri;
    logic [UW-1:0] r_given, r_missing, r_cum, r_out_cum;
    logic [PW-1:0] r_prod;

    logic [WB-1:0] w_rdata, w_eff;
    logic [UW-1:0] f_rdata, c_rdata, freq_new, pre_sum, rd_val, f_wdata;
    logic [SW-1:0] m_rdata, div_rem;
    logic [PW-1:0] div_q;
    logic          div_busy, take_wr, cum_we, out_free, load, beats, bump, f_we;
    logic [IW-1:0] k_idx, j_idx;
    logic [CW-1:0] clamp_idx;

    assign k_idx    = r_k[IW-1:0];
    assign j_idx    = r_j[IW-1:0];
    assign w_eff    = r_wvd ? w_rdata : '0;
    assign take_wr  = i_cmd.take && (i_req_type == ftq_pkg::REQ_WRITE)
                      && (i_entry_index < CW'(NA));
    assign clamp_idx = (i_entry_index > CW'(NA)) ? CW'(NA) : i_entry_index;
    assign freq_new = UW'(1) + div_q[UW-1:0];
    // The extra count for a top-ranked remainder is folded into the stored frequency.
    assign bump     = UW'(r_rank) < r_missing;
    assign f_we     = (i_cmd.op == ftq_pkg::DOP_DWR) || (i_cmd.op == ftq_pkg::DOP_RDEC);
    assign f_wdata  = (i_cmd.op == ftq_pkg::DOP_RDEC) ? f_rdata + UW'(bump) : freq_new;
    assign pre_sum  = r_cum + f_rdata;
    assign cum_we   = (i_cmd.op == ftq_pkg::DOP_PRE) && r_pend;
    assign beats    = (m_rdata > r_ri) || ((m_rdata == r_ri) && (r_jd < k_idx));
    assign out_free = !r_ov || !i_out_stall;
    assign load     = out_free && ((i_cmd.op == ftq_pkg::DOP_RD_OUT)
                      || (i_cmd.op == ftq_pkg::DOP_FIN_OK)
                      || (i_cmd.op == ftq_pkg::DOP_FIN_ERR));
    // Entry zero of the built table is always zero and is never stored.
    assign rd_val   = r_built ? ((r_ridx == '0) ? '0 : c_rdata)
                              : UW'(UW'(r_ridx) * UW'(ftq_pkg::UNI_STEP));

    ftq_ram #(.W(WB), .DEPTH(NA)) u_wram (
        .i_clk(i_clk), .i_we(take_wr), .i_waddr(i_entry_index[IW-1:0]),
        .i_wdata(i_weight[WB-1:0]), .i_raddr(k_idx), .o_rdata(w_rdata)
    );
    ftq_ram #(.W(UW), .DEPTH(NA)) u_fram (
        .i_clk(i_clk), .i_we(f_we), .i_waddr(k_idx),
        .i_wdata(f_wdata), .i_raddr(k_idx), .o_rdata(f_rdata)
    );
    ftq_ram #(.W(SW), .DEPTH(NA)) u_mram (
        .i_clk(i_clk), .i_we(i_cmd.op == ftq_pkg::DOP_DWR), .i_waddr(k_idx),
        .i_wdata(div_rem),
        .i_raddr((i_cmd.op == ftq_pkg::DOP_RSCAN) ? j_idx : k_idx), .o_rdata(m_rdata)
    );
    ftq_ram #(.W(UW), .DEPTH(NA + 1)) u_cram (
        .i_clk(i_clk), .i_we(cum_we), .i_waddr(CW'(r_kd) + CW'(1)),
        .i_wdata(pre_sum), .i_raddr(r_ridx), .o_rdata(c_rdata)
    );
    ftq_div #(.N_W(PW), .D_W(SW)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_cmd.op == ftq_pkg::DOP_DSTART),
        .i_dividend(r_prod), .i_divisor(r_sum), .o_busy(div_busy),
        .o_quot(div_q), .o_rem(div_rem)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wv    <= '0;
            r_built <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            if (take_wr) begin
                r_wv[i_entry_index[IW-1:0]] <= 1'b1;
            end
            if (i_cmd.op == ftq_pkg::DOP_FIN_OK) begin
                r_built <= 1'b1;
            end
            if (load) begin
                r_ov <= 1'b1;
            end else if (!i_out_stall) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_wvd <= r_wv[k_idx];
        if (load) begin
            r_out_cum <= (i_cmd.op == ftq_pkg::DOP_RD_OUT) ? rd_val : '0;
            r_out_st  <= i_cmd.op == ftq_pkg::DOP_FIN_ERR;
        end
        case (i_cmd.op)
            ftq_pkg::DOP_IDLE: begin
                if (i_cmd.take && (i_req_type == ftq_pkg::REQ_READ)) begin
                    r_ridx <= clamp_idx;
                end
                r_k    <= '0;
                r_sum  <= '0;
                r_pend <= 1'b0;
            end
            ftq_pkg::DOP_SUM: begin
                if (r_pend) begin
                    r_sum <= r_sum + SW'(w_eff);
                end
                r_pend <= r_k < CW'(NA);
                r_k    <= r_k + CW'(1);
            end
            ftq_pkg::DOP_KCLR: begin
                r_k     <= '0;
                r_given <= '0;
            end
            ftq_pkg::DOP_DMUL: begin
                r_prod <= PW'(w_eff) * PW'(ftq_pkg::SPREAD);
            end
            ftq_pkg::DOP_DWR: begin
                r_given <= r_given + freq_new;
                r_k     <= r_k + CW'(1);
            end
            ftq_pkg::DOP_MISS: begin
                r_missing <= UW'(ftq_pkg::CDF_TOTAL) - r_given;
                r_k       <= '0;
            end
            ftq_pkg::DOP_RLD: begin
                r_ri   <= m_rdata;
                r_j    <= '0;
                r_rank <= '0;
                r_pend <= 1'b0;
            end
            ftq_pkg::DOP_RSCAN: begin
                if (r_pend && beats) begin
                    r_rank <= r_rank + CW'(1);
                end
                r_pend <= r_j < CW'(NA);
                r_jd   <= j_idx;
                r_j    <= r_j + CW'(1);
            end
            ftq_pkg::DOP_RDEC: begin
                r_k <= r_k + CW'(1);
            end
            ftq_pkg::DOP_PCLR: begin
                r_k    <= '0;
                r_cum  <= '0;
                r_pend <= 1'b0;
            end
            ftq_pkg::DOP_PRE: begin
                if (r_pend) begin
                    r_cum <= pre_sum;
                end
                r_pend <= r_k < CW'(NA);
                r_kd   <= k_idx;
                r_k    <= r_k + CW'(1);
            end
            default: ;
        endcase
    end

    assign o_stat.k_last    = r_k == CW'(NA - 1);
    assign o_stat.k_end     = r_k == CW'(NA);
    assign o_stat.j_end     = r_j == CW'(NA);
    assign o_stat.div_busy  = div_busy;
    assign o_stat.sum_zero  = r_sum == '0;
    assign o_stat.miss_zero = r_given == UW'(ftq_pkg::CDF_TOTAL);
    assign o_stat.out_free  = out_free;

    assign o_valid     = r_ov;
    assign o_cum_value = r_out_cum;
    assign o_status    = r_out_st;

`ifndef ASSERT_OFF
    a_cum_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cum_we |-> (r_k == CW'(r_kd) + CW'(1)))
        else $error("cum table write address out of order");
    a_div_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ftq_pkg::DOP_DWR) |-> !div_busy)
        else $error("frequency stored while the divider is still running");
    a_given: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ftq_pkg::DOP_MISS) |-> (r_given <= UW'(ftq_pkg::CDF_TOTAL)))
        else $error("floor counts exceed the table total");
    a_missing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == ftq_pkg::DOP_RDEC) |-> (r_missing < UW'(NA)))
        else $error("missing count not below the alphabet size");
`endif
endmodule
`default_nettype wire

// ===== rtl/core/ftq_ctrl.sv =====
// Controller state machine that sequences writes, reads and table builds.
`default_nettype none
module ftq_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    input  wire logic [1:0]    i_req_type,
    input  wire ftq_pkg::t_stat i_stat,
    output ftq_pkg::t_cmd      o_cmd,
    output logic               o_stall
);
    ftq_pkg::t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ftq_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd.take  = 1'b0;
        o_cmd.op    = ftq_pkg::DOP_NONE;
        unique case (r_state)
            ftq_pkg::S_IDLE: begin
                o_cmd.op   = ftq_pkg::DOP_IDLE;
                o_cmd.take = i_valid;
                if (i_valid && (i_req_type == ftq_pkg::REQ_READ)) begin
                    n_state = ftq_pkg::S_RD_WAIT;
                end else if (i_valid && (i_req_type == ftq_pkg::REQ_BUILD)) begin
                    n_state = ftq_pkg::S_SUM;
                end
            end
            ftq_pkg::S_RD_WAIT: n_state = ftq_pkg::S_RD_OUT;
            ftq_pkg::S_RD_OUT: begin
                o_cmd.op = ftq_pkg::DOP_RD_OUT;
                if (i_stat.out_free) n_state = ftq_pkg::S_IDLE;
            end
            ftq_pkg::S_SUM: begin
                o_cmd.op = ftq_pkg::DOP_SUM;
                if (i_stat.k_end) n_state = ftq_pkg::S_CHECK;
            end
            ftq_pkg::S_CHECK: begin
                o_cmd.op = ftq_pkg::DOP_KCLR;
                n_state  = i_stat.sum_zero ? ftq_pkg::S_FIN_ERR : ftq_pkg::S_DV_RD;
            end
            ftq_pkg::S_DV_RD: begin
                o_cmd.op = ftq_pkg::DOP_DRD;
                n_state  = ftq_pkg::S_DV_MUL;
            end
            ftq_pkg::S_DV_MUL: begin
                o_cmd.op = ftq_pkg::DOP_DMUL;
                n_state  = ftq_pkg::S_DV_START;
            end
            ftq_pkg::S_DV_START: begin
                o_cmd.op = ftq_pkg::DOP_DSTART;
                n_state  = ftq_pkg::S_DV_RUN;
            end
            ftq_pkg::S_DV_RUN: begin
                if (!i_stat.div_busy) n_state = ftq_pkg::S_DV_WR;
            end
            ftq_pkg::S_DV_WR: begin
                o_cmd.op = ftq_pkg::DOP_DWR;
                n_state  = i_stat.k_last ? ftq_pkg::S_MISS : ftq_pkg::S_DV_RD;
            end
            ftq_pkg::S_MISS: begin
                o_cmd.op = ftq_pkg::DOP_MISS;
                n_state  = i_stat.miss_zero ? ftq_pkg::S_PRE_CLR : ftq_pkg::S_RK_RD;
            end
            ftq_pkg::S_RK_RD: begin
                o_cmd.op = ftq_pkg::DOP_RRD;
                n_state  = ftq_pkg::S_RK_LD;
            end
            ftq_pkg::S_RK_LD: begin
                o_cmd.op = ftq_pkg::DOP_RLD;
                n_state  = ftq_pkg::S_RK_SCAN;
            end
            ftq_pkg::S_RK_SCAN: begin
                o_cmd.op = ftq_pkg::DOP_RSCAN;
                if (i_stat.j_end) n_state = ftq_pkg::S_RK_DEC;
            end
            ftq_pkg::S_RK_DEC: begin
                o_cmd.op = ftq_pkg::DOP_RDEC;
                n_state  = i_stat.k_last ? ftq_pkg::S_PRE_CLR : ftq_pkg::S_RK_RD;
            end
            ftq_pkg::S_PRE_CLR: begin
                o_cmd.op = ftq_pkg::DOP_PCLR;
                n_state  = ftq_pkg::S_PRE;
            end
            ftq_pkg::S_PRE: begin
                o_cmd.op = ftq_pkg::DOP_PRE;
                if (i_stat.k_end) n_state = ftq_pkg::S_FIN_OK;
            end
            ftq_pkg::S_FIN_OK: begin
                o_cmd.op = ftq_pkg::DOP_FIN_OK;
                if (i_stat.out_free) n_state = ftq_pkg::S_IDLE;
            end
            ftq_pkg::S_FIN_ERR: begin
                o_cmd.op = ftq_pkg::DOP_FIN_ERR;
                if (i_stat.out_free) n_state = ftq_pkg::S_IDLE;
            end
            default: n_state = ftq_pkg::S_IDLE;
        endcase
    end

    assign o_stall = r_state != ftq_pkg::S_IDLE;
endmodule
`default_nettype wire

// ===== rtl/core/frequency_table_quantizer.sv =====
// Weight write: one word per cycle while idle. Table read: the index is registered,
// the table is read, and the result word is loaded into the output register, where
// it is held while the output is stalled; the next request is accepted only after
// that load. Build: a sum pass, one iterative division per entry, a remainder ranking
// via the single remainder read port when counts are missing, and a prefix pass.
// Reset is synchronous: weights read as zero and the table as uniform until a build succeeds.
`default_nettype none
module frequency_table_quantizer (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_req_type,
    input  wire logic [8:0]  i_entry_index,
    input  wire logic [15:0] i_weight,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [16:0]      o_cum_value,
    output logic             o_status
);
    ftq_pkg::t_cmd  cmd;
    ftq_pkg::t_stat stat;

    ftq_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .i_req_type(i_req_type),
        .i_stat(stat), .o_cmd(cmd), .o_stall(o_stall)
    );

    ftq_dp u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_req_type(i_req_type),
        .i_entry_index(i_entry_index), .i_weight(i_weight), .i_out_stall(i_stall),
        .o_stat(stat), .o_valid(o_valid), .o_cum_value(o_cum_value), .o_status(o_status)
    );
endmodule
`default_nettype wire
